>>> hw/rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared opcodes for the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;
    localparam logic [2:0] OP_SCAN   = 3'd0;
    localparam logic [2:0] OP_SCANI  = 3'd1;
    localparam logic [2:0] OP_BEST   = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_COUNT  = 3'd4;
endpackage

>>> hw/rtl/bra_ram.sv
// ----------------------------------------------------------------------------
// bra_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/bitmap_run_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator_core
// Bitmap block allocator: first fit, first fit with invert, best fit, range set and range count.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes one request transaction: opcode,
// start index, run length and bit value. The output channel (o_valid/i_ready)
// returns one result transaction per request. i_cfg_we writes bits_in_use.
// The map lives in one RAM of MAP_BITS/WORD_BITS words, read one word at a
// time through a registered read port. A search passes the map bit by bit:
// one bit per cycle of a walk over [start, n), held while each word touched
// is read. Scan and invert and best fit then take a second walk over the run
// that writes words back; set range takes only that write walk and count
// only the read walk over its range.
// After reset a clearing pass writes every word to zero with o_ready low.
// One request is in work at a time; a finished result goes to the output
// register when it is free, and the core then returns to idle for the next
// request. A second result waits in the core while the receiver stalls, and
// o_ready stays low until the first result is taken.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_core #(
    parameter int MAP_BITS  = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [10:0] i_start_index,
    input  logic [10:0] i_run_length,
    input  logic        i_bit_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_position,
    output logic        o_found,
    output logic [10:0] o_tally,
    output logic        o_range_error
);
    localparam int NW = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int IW = $clog2(MAP_BITS + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_WRD  = 3'd4;
    localparam logic [2:0] S_WMOD = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]    r_st, n_st;
    logic [10:0]   r_biu;
    logic [2:0]    r_op;
    logic [IW-1:0] r_start, r_len, r_n, r_i, r_run, r_pos, r_hs, r_best;
    logic          r_v, r_have, r_wv, r_scanned;
    logic [IW-1:0] r_wpos, r_wend;
    logic [IW-1:0] r_tally;
    logic [WORD_BITS-1:0] r_word;
    logic          r_found, r_err;
    logic          r_ovalid;
    logic [10:0]   r_opos, r_otally;
    logic          r_ofound, r_oerr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    bra_ram #(.WIDTH(WORD_BITS), .DEPTH(NW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic [IW-1:0] n_clip;
    assign n_clip = ({1'b0, r_biu} < 12'(MAP_BITS)) ? IW'(r_biu) : IW'(MAP_BITS);

    logic [AW-1:0] i_word, w_word;
    logic [BW-1:0] i_bit, w_bit;
    assign i_word = AW'(r_i / WORD_BITS);
    assign i_bit  = BW'(r_i % WORD_BITS);
    assign w_word = AW'(r_wpos / WORD_BITS);
    assign w_bit  = BW'(r_wpos % WORD_BITS);

    logic cur_bit, match, in_range;
    assign cur_bit  = r_word[i_bit];
    assign match    = (cur_bit == r_v);
    assign in_range = (r_i < r_n);

    logic [IW:0] run_inc;
    assign run_inc = match ? ({1'b0, r_run} + 1'b1) : '0;

    logic [WORD_BITS-1:0] mod_word;
    always_comb begin
        mod_word = r_word;
        mod_word[w_bit] = r_wv;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = w_word;
        ram_wdata = mod_word;
        ram_raddr = i_word;
        if (r_st == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_i);
            ram_wdata = '0;
        end else if (r_st == S_WRD || r_st == S_WMOD) begin
            ram_raddr = w_word;
            ram_we    = (r_st == S_WMOD) &&
                        ((w_bit == BW'(WORD_BITS - 1)) || (r_wpos + 1'b1 == r_wend));
        end
    end

    assign o_ready       = (r_st == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_position    = r_opos;
    assign o_found       = r_ofound;
    assign o_tally       = r_otally;
    assign o_range_error = r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_biu    <= 11'd1024;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_biu <= i_cfg_wdata;
            end
            if (r_ovalid && i_ready && r_st != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_CLR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == IW'(NW - 1)) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op      <= i_opcode;
                        r_v       <= i_bit_value;
                        r_len     <= IW'(i_run_length);
                        r_start   <= IW'(i_start_index);
                        r_n       <= n_clip;
                        r_run     <= '0;
                        r_tally   <= '0;
                        r_have    <= 1'b0;
                        r_found   <= 1'b0;
                        r_err     <= 1'b0;
                        r_pos     <= '0;
                        r_best    <= '0;
                        r_hs      <= '0;
                        r_scanned <= 1'b0;
                        r_st      <= S_OUT;
                        case (i_opcode)
                            bra_pkg::OP_SCAN, bra_pkg::OP_SCANI: begin
                                if ({1'b0, i_start_index} > 12'(n_clip)) begin
                                    r_err <= 1'b1;
                                end else if ({1'b0, i_run_length} > 12'(n_clip)) begin
                                    r_st <= S_OUT;
                                end else if (i_run_length == '0) begin
                                    r_found <= 1'b1;
                                    r_pos   <= IW'(i_start_index);
                                end else begin
                                    r_i  <= IW'(i_start_index);
                                    r_st <= S_RD;
                                end
                            end
                            bra_pkg::OP_BEST: begin
                                if (i_run_length == '0) begin
                                    r_found <= 1'b1;
                                end else if ({1'b0, i_run_length} <= 12'(n_clip)) begin
                                    r_i  <= '0;
                                    r_st <= S_RD;
                                end
                            end
                            bra_pkg::OP_SET, bra_pkg::OP_COUNT: begin
                                if ({1'b0, i_start_index} > 12'(n_clip) ||
                                    {1'b0, i_run_length} >
                                        12'(n_clip) - {1'b0, i_start_index}) begin
                                    r_err <= 1'b1;
                                end else if (i_run_length != '0) begin
                                    r_i    <= IW'(i_start_index);
                                    r_wpos <= IW'(i_start_index);
                                    r_wend <= IW'(i_start_index) + IW'(i_run_length);
                                    r_wv   <= i_bit_value;
                                    r_n    <= IW'(i_start_index) + IW'(i_run_length);
                                    r_st   <= (i_opcode == bra_pkg::OP_SET) ? S_WRD : S_RD;
                                end
                            end
                            default: begin
                                r_st <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (r_scanned) begin
                        r_word <= ram_rdata;
                        r_st   <= S_SCAN;
                    end
                    r_scanned <= ~r_scanned;
                end
                S_SCAN: begin
                    if (!in_range) begin
                        if (r_op == bra_pkg::OP_BEST) begin
                            if (r_run != '0 && {1'b0, r_run} >= {1'b0, r_len} &&
                                (!r_have || r_run <= r_best)) begin
                                r_have <= 1'b1;
                                r_found <= 1'b1;
                                r_pos  <= r_hs;
                                r_wpos <= r_hs;
                                r_wend <= r_hs + r_len;
                                r_wv   <= ~r_v;
                                r_st   <= S_WRD;
                            end else if (r_have) begin
                                r_found <= 1'b1;
                                r_wpos <= r_pos;
                                r_wend <= r_pos + r_len;
                                r_wv   <= ~r_v;
                                r_st   <= S_WRD;
                            end else begin
                                r_st <= S_OUT;
                            end
                        end else begin
                            r_st <= S_OUT;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (i_bit == BW'(WORD_BITS - 1)) begin
                            r_st <= S_RD;
                        end
                        case (r_op)
                            bra_pkg::OP_COUNT: begin
                                if (match) begin
                                    r_tally <= r_tally + 1'b1;
                                end
                            end
                            bra_pkg::OP_BEST: begin
                                r_run <= IW'(run_inc);
                                if (match && r_run == '0) begin
                                    r_hs <= r_i;
                                end
                                if (!match && r_run != '0 &&
                                    {1'b0, r_run} >= {1'b0, r_len} &&
                                    (!r_have || r_run <= r_best)) begin
                                    r_have <= 1'b1;
                                    r_best <= r_run;
                                    r_pos  <= r_hs;
                                end
                            end
                            default: begin
                                r_run <= IW'(run_inc);
                                if (run_inc >= {1'b0, r_len}) begin
                                    r_found <= 1'b1;
                                    r_pos   <= r_i + 1'b1 - r_len;
                                    if (r_op == bra_pkg::OP_SCANI) begin
                                        r_wpos <= r_i + 1'b1 - r_len;
                                        r_wend <= r_i + 1'b1;
                                        r_wv   <= ~r_v;
                                        r_st   <= S_WRD;
                                    end else begin
                                        r_st <= S_OUT;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_WRD: begin
                    if (r_scanned) begin
                        r_word <= ram_rdata;
                        r_st   <= S_WMOD;
                    end
                    r_scanned <= ~r_scanned;
                end
                S_WMOD: begin
                    r_word[w_bit] <= r_wv;
                    r_wpos <= r_wpos + 1'b1;
                    if (r_wpos + 1'b1 == r_wend) begin
                        r_st <= S_OUT;
                    end else if (w_bit == BW'(WORD_BITS - 1)) begin
                        r_st <= S_WRD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_opos   <= r_found ? 11'(r_pos) : '0;
                        r_ofound <= r_found;
                        r_otally <= 11'(r_tally);
                        r_oerr   <= r_err;
                        r_st     <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_st == S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> !o_range_error)
        else $error("found with range error");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_st == S_CLR || r_st == S_WMOD))
        else $error("stray memory write");
endmodule
